// File: src/lwdb_pkg.sv
// lwdb_pkg: shared types, constants and microcode table of the wet/dry blend
// no dependencies; used by every module of the block
`default_nettype none

package lwdb_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int WEIGHT_W   = 25;
   localparam int OPB_W      = 26;
   localparam int LAT_W      = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 25;
   localparam int PC_W       = 4;

   localparam logic [WEIGHT_W-1:0] Q_ONE = 25'h1000000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_LATENCY     = 3'd0,
      REG_MIX_TARGET  = 3'd1,
      REG_ENABLE      = 3'd2,
      REG_SMOOTH_COEF = 3'd3,
      REG_RISE_COEF   = 3'd4,
      REG_FALL_COEF   = 3'd5,
      REG_BYPASS      = 3'd6
   } csr_reg_type;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE       = 4'd0;
   localparam pc_type PC_GAIN_MUL   = 4'd1;
   localparam pc_type PC_MIX_MUL    = 4'd2;
   localparam pc_type PC_FADE_MUL   = 4'd3;
   localparam pc_type PC_DRY_L_MUL  = 4'd4;
   localparam pc_type PC_WET_L_MUL  = 4'd5;
   localparam pc_type PC_DRY_R_MUL  = 4'd6;
   localparam pc_type PC_WET_R_MUL  = 4'd7;
   localparam pc_type PC_MIX_OUT    = 4'd8;
   localparam pc_type PC_BYPASS_OUT = 4'd9;

   typedef enum logic [2:0] {
      OPA_MIX,
      OPA_MIX_ERR,
      OPA_FADE_ERR,
      OPA_DRY_L,
      OPA_WET_L,
      OPA_DRY_R,
      OPA_WET_R
   } opa_sel_type;

   typedef enum logic [2:0] {
      OPB_FADE,
      OPB_SMOOTH,
      OPB_FADE_COEF,
      OPB_DRY_GAIN,
      OPB_WET_GAIN
   } opb_sel_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_GAIN,
      DST_MIX,
      DST_FADE,
      DST_ACC,
      DST_OUT_L,
      DST_EMIT_MIX,
      DST_EMIT_BYP
   } dst_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_WAIT_REQ,
      JMP_BYPASS,
      JMP_WAIT_OUT
   } jmp_sel_type;

   typedef struct packed {
      opa_sel_type opa;
      opb_sel_type opb;
      dst_sel_type dst;
      jmp_sel_type jmp;
      pc_type      target;
   } ucode_type;

   typedef struct packed {
      logic                fire;
      logic                accept;
   } seq_stat_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] mix_target;
      logic                enable;
      logic [WEIGHT_W-1:0] smooth_coef;
      logic [WEIGHT_W-1:0] rise_coef;
      logic [WEIGHT_W-1:0] fall_coef;
   } mix_cfg_type;

   // weights above one are held at one
   function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] v);
      logic [WEIGHT_W-1:0] r;
      r = (v > Q_ONE) ? Q_ONE : v;
      return r;
   endfunction

   // control store: one word per step
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type uc;
      uc = '{opa: OPA_MIX, opb: OPB_FADE, dst: DST_NONE, jmp: JMP_NEXT, target: PC_IDLE};
      unique case (pc)
         PC_IDLE: begin
            uc.jmp    = JMP_WAIT_REQ;
            uc.target = PC_GAIN_MUL;
         end
         PC_GAIN_MUL: begin
            uc.jmp    = JMP_BYPASS;
            uc.target = PC_BYPASS_OUT;
         end
         PC_MIX_MUL: begin
            uc.opa = OPA_MIX_ERR;
            uc.opb = OPB_SMOOTH;
            uc.dst = DST_GAIN;
         end
         PC_FADE_MUL: begin
            uc.opa = OPA_FADE_ERR;
            uc.opb = OPB_FADE_COEF;
            uc.dst = DST_MIX;
         end
         PC_DRY_L_MUL: begin
            uc.opa = OPA_DRY_L;
            uc.opb = OPB_DRY_GAIN;
            uc.dst = DST_FADE;
         end
         PC_WET_L_MUL: begin
            uc.opa = OPA_WET_L;
            uc.opb = OPB_WET_GAIN;
            uc.dst = DST_ACC;
         end
         PC_DRY_R_MUL: begin
            uc.opa = OPA_DRY_R;
            uc.opb = OPB_DRY_GAIN;
            uc.dst = DST_OUT_L;
         end
         PC_WET_R_MUL: begin
            uc.opa = OPA_WET_R;
            uc.opb = OPB_WET_GAIN;
            uc.dst = DST_ACC;
         end
         PC_MIX_OUT: begin
            uc.dst    = DST_EMIT_MIX;
            uc.jmp    = JMP_WAIT_OUT;
            uc.target = PC_IDLE;
         end
         PC_BYPASS_OUT: begin
            uc.dst    = DST_EMIT_BYP;
            uc.jmp    = JMP_WAIT_OUT;
            uc.target = PC_IDLE;
         end
         default: begin
            uc.jmp    = JMP_WAIT_OUT;
            uc.target = PC_IDLE;
         end
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

// File: src/lwdb_seq.sv
// lwdb_seq: step counter and control store fetch for the blend datapath
// depends on lwdb_pkg
`default_nettype none

module lwdb_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               out_free,
   input  wire logic               bypass,
   output logic                    req_ready,
   output lwdb_pkg::ucode_type     ctl,
   output lwdb_pkg::seq_stat_type  stat
);
   import lwdb_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;

   assign ctl       = ucode_rom(pc_ff);
   assign req_ready = (ctl.jmp == JMP_WAIT_REQ);

   always_comb begin
      stat.accept = req_valid && req_ready;
      case (ctl.jmp)
         JMP_WAIT_REQ: stat.fire = req_valid;
         JMP_WAIT_OUT: stat.fire = out_free;
         default:      stat.fire = 1'b1;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (stat.fire) begin
         if (ctl.jmp == JMP_NEXT || (ctl.jmp == JMP_BYPASS && !bypass)) begin
            pc_in = pc_ff + 1'b1;
         end else begin
            pc_in = ctl.target;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: src/lwdb_ring.sv
// lwdb_ring: dry delay memory, stereo, with fill tracking in place of a clear
// depends on lwdb_pkg
`default_nettype none

module lwdb_ring #(
   parameter int RING_DEPTH  = 64,
   parameter int SAMPLE_BITS = 24,
   parameter int AW          = $clog2(RING_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [AW-1:0]                 lat,
   input  wire logic signed [SAMPLE_BITS-1:0] x_l,
   input  wire logic signed [SAMPLE_BITS-1:0] x_r,
   output logic signed [SAMPLE_BITS-1:0]      dly_l,
   output logic signed [SAMPLE_BITS-1:0]      dly_r
);
   import lwdb_pkg::*;

   logic [2*SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [2*SAMPLE_BITS-1:0] q_ff;
   logic [2*SAMPLE_BITS-1:0] x_ff;
   logic [AW-1:0]            wr_idx_ff;
   logic [AW-1:0]            wr_idx_in;
   logic                     wrapped_ff;
   logic                     valid_ff;
   logic [AW:0]              diff;
   logic [AW:0]              diff_wrap;
   logic [AW-1:0]            rd_addr;
   logic                     lat_zero;
   logic                     step_ring;
   logic                     last_idx;

   assign lat_zero  = (lat == '0);
   assign step_ring = accept && !lat_zero;
   assign diff      = {1'b0, wr_idx_ff} - {1'b0, lat};
   assign diff_wrap = diff + (AW+1)'(RING_DEPTH);
   assign rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
   assign last_idx  = (wr_idx_ff == AW'(RING_DEPTH - 1));
   assign wr_idx_in = last_idx ? '0 : wr_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (step_ring) begin
         ring_mem[wr_idx_ff] <= {x_r, x_l};
         q_ff                <= ring_mem[rd_addr];
      end
      if (accept) begin
         x_ff <= {x_r, x_l};
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff  <= '0;
         wrapped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (step_ring) begin
         valid_ff   <= wrapped_ff || (rd_addr < wr_idx_ff);
         wr_idx_ff  <= wr_idx_in;
         wrapped_ff <= wrapped_ff || last_idx;
      end
   end

   always_comb begin
      if (lat_zero) begin
         dly_l = x_ff[SAMPLE_BITS-1:0];
         dly_r = x_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end else if (valid_ff) begin
         dly_l = q_ff[SAMPLE_BITS-1:0];
         dly_r = q_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end else begin
         dly_l = '0;
         dly_r = '0;
      end
   end

endmodule

`default_nettype wire

// File: src/lwdb_dp.sv
// lwdb_dp: shared multiplier, accumulator and smoother state of the blend
// depends on lwdb_pkg; driven by lwdb_seq control words
`default_nettype none

module lwdb_dp #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lwdb_pkg::ucode_type           ctl,
   input  wire lwdb_pkg::seq_stat_type        stat,
   input  wire lwdb_pkg::mix_cfg_type         cfg,
   input  wire logic signed [SAMPLE_BITS-1:0] wet_l,
   input  wire logic signed [SAMPLE_BITS-1:0] wet_r,
   input  wire logic signed [SAMPLE_BITS-1:0] dry_l,
   input  wire logic signed [SAMPLE_BITS-1:0] dry_r,
   output logic signed [SAMPLE_BITS-1:0]      res_l,
   output logic signed [SAMPLE_BITS-1:0]      res_r
);
   import lwdb_pkg::*;

   localparam int OPA_W = ((SAMPLE_BITS > OPB_W) ? SAMPLE_BITS : OPB_W) + 1;
   localparam int PW    = OPA_W + OPB_W;
   localparam int UPD_W = WEIGHT_W + 2;

   function automatic logic [WEIGHT_W-1:0] clamp_w(input logic [UPD_W-1:0] v);
      logic [WEIGHT_W-1:0] r;
      if (v[UPD_W-1]) begin
         r = '0;
      end else if (v[UPD_W-2:0] > {1'b0, Q_ONE}) begin
         r = Q_ONE;
      end else begin
         r = v[WEIGHT_W-1:0];
      end
      return r;
   endfunction

   logic [WEIGHT_W-1:0]          mix_ff;
   logic [WEIGHT_W-1:0]          fade_ff;
   logic [WEIGHT_W-1:0]          gain_ff;
   logic signed [SAMPLE_BITS-1:0] wet_l_ff;
   logic signed [SAMPLE_BITS-1:0] wet_r_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff;
   logic signed [PW-1:0]         prod_ff;
   logic signed [PW-1:0]         acc_ff;
   logic signed [PW-1:0]         prod_in;
   logic signed [OPA_W-1:0]      opa;
   logic signed [OPB_W-1:0]      opb;
   logic signed [OPB_W-1:0]      mix_err;
   logic signed [OPB_W-1:0]      fade_err;
   logic [WEIGHT_W-1:0]          fade_tgt;
   logic [WEIGHT_W-1:0]          dry_gain;
   logic                         fade_below;
   logic signed [PW:0]           blend_sum;
   logic signed [SAMPLE_BITS-1:0] blend_res;
   logic [UPD_W-1:0]             upd_step;
   logic [UPD_W-1:0]             mix_upd;
   logic [UPD_W-1:0]             fade_upd;

   assign fade_tgt   = cfg.enable ? Q_ONE : '0;
   assign fade_below = cfg.enable && (fade_ff < Q_ONE);
   assign mix_err    = signed'({1'b0, cfg.mix_target}) - signed'({1'b0, mix_ff});
   assign fade_err   = signed'({1'b0, fade_tgt}) - signed'({1'b0, fade_ff});
   assign dry_gain   = Q_ONE - gain_ff;

   always_comb begin
      case (ctl.opa)
         OPA_MIX:      opa = signed'({{(OPA_W-WEIGHT_W){1'b0}}, mix_ff});
         OPA_MIX_ERR:  opa = signed'({{(OPA_W-OPB_W){mix_err[OPB_W-1]}}, mix_err});
         OPA_FADE_ERR: opa = signed'({{(OPA_W-OPB_W){fade_err[OPB_W-1]}}, fade_err});
         OPA_DRY_L:    opa = signed'({{(OPA_W-SAMPLE_BITS){dry_l[SAMPLE_BITS-1]}}, dry_l});
         OPA_WET_L:    opa = signed'({{(OPA_W-SAMPLE_BITS){wet_l_ff[SAMPLE_BITS-1]}},
                                      wet_l_ff});
         OPA_DRY_R:    opa = signed'({{(OPA_W-SAMPLE_BITS){dry_r[SAMPLE_BITS-1]}}, dry_r});
         OPA_WET_R:    opa = signed'({{(OPA_W-SAMPLE_BITS){wet_r_ff[SAMPLE_BITS-1]}},
                                      wet_r_ff});
         default:      opa = '0;
      endcase
   end

   always_comb begin
      case (ctl.opb)
         OPB_FADE:      opb = signed'({1'b0, fade_ff});
         OPB_SMOOTH:    opb = signed'({1'b0, cfg.smooth_coef});
         OPB_FADE_COEF: opb = signed'({1'b0, fade_below ? cfg.rise_coef : cfg.fall_coef});
         OPB_DRY_GAIN:  opb = signed'({1'b0, dry_gain});
         OPB_WET_GAIN:  opb = signed'({1'b0, gain_ff});
         default:       opb = '0;
      endcase
   end

   assign prod_in = opa * opb;

   // floor of the q24 sum and product: arithmetic bits above the fraction
   assign blend_sum = {acc_ff[PW-1], acc_ff} + {prod_ff[PW-1], prod_ff};
   assign blend_res = blend_sum[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
   assign upd_step  = prod_ff[FRAC_BITS+UPD_W-1:FRAC_BITS];
   assign mix_upd   = {2'b00, mix_ff} + upd_step;
   assign fade_upd  = {2'b00, fade_ff} + upd_step;

   always_comb begin
      if (ctl.dst == DST_EMIT_BYP) begin
         res_l = dry_l;
         res_r = dry_r;
      end else begin
         res_l = out_l_ff;
         res_r = blend_res;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.accept) begin
         wet_l_ff <= wet_l;
         wet_r_ff <= wet_r;
      end
      if (stat.fire) begin
         prod_ff <= prod_in;
         case (ctl.dst)
            DST_GAIN:  gain_ff  <= prod_ff[FRAC_BITS+WEIGHT_W-1:FRAC_BITS];
            DST_ACC:   acc_ff   <= prod_ff;
            DST_OUT_L: out_l_ff <= blend_res;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff  <= '0;
         fade_ff <= '0;
      end else if (stat.fire) begin
         if (ctl.dst == DST_MIX) begin
            mix_ff <= clamp_w(mix_upd);
         end
         if (ctl.dst == DST_FADE) begin
            fade_ff <= clamp_w(fade_upd);
         end
      end
   end

endmodule

`default_nettype wire

// File: src/latency_aligned_wet_dry_blend.sv
// latency_aligned_wet_dry_blend: top level, configuration registers and result register
// depends on lwdb_pkg, lwdb_seq, lwdb_ring and lwdb_dp
`default_nettype none

// stereo dry/wet blend with the dry path delayed to match the effect latency
// req_ channel: one transaction carries one stereo frame of dry and wet samples
// rsp_ channel: one transaction per frame with the blended left and right samples
// csr_ port: plain write port, taken whenever csr_we is high; write only while idle
// a mixed frame goes from acceptance to the result register through the accept
// step and then eight microcode steps that share a single multiplier for the seven
// products (gain, both smoothers, four sample terms); in bypass a frame goes from
// the gain step straight to the bypass output step and the smoothers hold
// a new frame is taken only while the sequencer sits in its idle step
// the dry ring holds RING_DEPTH frames; a latency of zero takes the direct path
// reset clears the csr registers, the smoothers and the ring bookkeeping; ring entries
// not yet written read as zero through fill tracking, so there is no clearing pass
// a stalled receiver leaves the result in the output register; the next frame is
// still accepted and computed, and the sequencer waits in its last step until the
// output register is free

module latency_aligned_wet_dry_blend #(
   parameter int RING_DEPTH  = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // dry_left, dry_right, wet_left, wet_right from bit 0 up
   input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // out_left, out_right from bit 0 up
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_we,
   input  wire logic [lwdb_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  wire logic [lwdb_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lwdb_pkg::*;

   localparam int AW    = $clog2(RING_DEPTH);
   localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

   // configuration registers; weights held at one when written above it
   mix_cfg_type   cfg_ff;
   logic [AW-1:0] lat_ff;
   logic          bypass_ff;
   logic [LAT_W-1:0] lat_wr;

   // result register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_l_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_r_ff;

   ucode_type     ctl;
   seq_stat_type  stat;
   logic          out_free;
   logic          emit;
   logic signed [SAMPLE_BITS-1:0] dry_l_in, dry_r_in, wet_l_in, wet_r_in;
   logic signed [SAMPLE_BITS-1:0] dly_l, dly_r;
   logic signed [SAMPLE_BITS-1:0] res_l, res_r;

   // field unpacking, lowest field first
   assign dry_l_in = req_tdata[SAMPLE_BITS-1:0];
   assign dry_r_in = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign wet_l_in = req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
   assign wet_r_in = req_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

   assign lat_wr = csr_wdata[LAT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         lat_ff    <= '0;
         bypass_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_LATENCY: begin
               // latency beyond the ring saturates to its last entry
               if (32'(lat_wr) > RING_DEPTH - 1) begin
                  lat_ff <= AW'(RING_DEPTH - 1);
               end else begin
                  lat_ff <= AW'(lat_wr);
               end
            end
            REG_MIX_TARGET:  cfg_ff.mix_target  <= sat_weight(csr_wdata[WEIGHT_W-1:0]);
            REG_ENABLE:      cfg_ff.enable      <= csr_wdata[0];
            REG_SMOOTH_COEF: cfg_ff.smooth_coef <= sat_weight(csr_wdata[WEIGHT_W-1:0]);
            REG_RISE_COEF:   cfg_ff.rise_coef   <= sat_weight(csr_wdata[WEIGHT_W-1:0]);
            REG_FALL_COEF:   cfg_ff.fall_coef   <= sat_weight(csr_wdata[WEIGHT_W-1:0]);
            REG_BYPASS:      bypass_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer: step counter over the control store
   lwdb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .bypass    (bypass_ff),
      .req_ready (req_tready),
      .ctl       (ctl),
      .stat      (stat)
   );

   // dry delay ring
   lwdb_ring #(
      .RING_DEPTH  (RING_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .AW          (AW)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .accept (stat.accept),
      .lat    (lat_ff),
      .x_l    (dry_l_in),
      .x_r    (dry_r_in),
      .dly_l  (dly_l),
      .dly_r  (dly_r)
   );

   // shared multiplier datapath
   lwdb_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat),
      .cfg   (cfg_ff),
      .wet_l (wet_l_in),
      .wet_r (wet_r_in),
      .dry_l (dly_l),
      .dry_r (dly_r),
      .res_l (res_l),
      .res_r (res_r)
   );

   // result register parts the sequencer from the receiver
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = stat.fire && (ctl.dst == DST_EMIT_MIX || ctl.dst == DST_EMIT_BYP);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_l_ff <= res_l;
         rsp_r_ff <= res_r;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_r_ff, rsp_l_ff});

endmodule

`default_nettype wire

// File: tb/sv/tb_latency_aligned_wet_dry_blend.sv
// tb_latency_aligned_wet_dry_blend: self-checking testbench of the latency-aligned wet/dry blend
// drives stereo frame transactions and csr writes, predicts every blended frame in place
// depends on lwdb_pkg and latency_aligned_wet_dry_blend
`timescale 1ns / 1ps

module tb_latency_aligned_wet_dry_blend;
   import lwdb_pkg::*;

   localparam int     RING_LEN    = 64;
   localparam int     GAP_MAX     = 14;
   localparam int     SETTLE      = 12;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint UNITY       = 64'd16777216;
   localparam logic [CSR_DATA_W-1:0] W_ONE  = Q_ONE;
   localparam logic [CSR_DATA_W-1:0] W_FULL = 25'h1FFFFFF;
   localparam logic [23:0] S_MAX = 24'h7FFFFF;
   localparam logic [23:0] S_MIN = 24'h800000;

   // one input transaction, dry_left in the lowest bits
   typedef struct packed {
      logic signed [23:0] wet_right;
      logic signed [23:0] wet_left;
      logic signed [23:0] dry_right;
      logic signed [23:0] dry_left;
   } frame_in_type;

   // one result transaction, out_left in the lowest bits
   typedef struct packed {
      logic signed [23:0] out_right;
      logic signed [23:0] out_left;
   } frame_out_type;

   logic                  clock;
   logic                  reset;
   logic [95:0]           req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   latency_aligned_wet_dry_blend uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),    // dry_left, dry_right, wet_left, wet_right from bit 0 up
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),    // out_left, out_right from bit 0 up
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // mirror of the block's registers as last written
   int     cfg_latency;
   longint cfg_mix_target, cfg_smooth, cfg_rise, cfg_fall;
   bit     cfg_enable, cfg_bypass;

   // mirror of the block's state
   logic signed [23:0] ring_left [RING_LEN];
   logic signed [23:0] ring_right[RING_LEN];
   int     ring_wr;
   longint mix_level;
   longint fade_level;

   frame_out_type expected_frames[$];

   bit     back_to_back;          // when set neither side idles
   longint cycle_count;
   int     frames_sent, frames_checked, bypass_frames, settings_used;
   int     mismatch_count, fail_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames still awaited",
                  cycle_count, expected_frames.size());
         $display("latency_aligned_wet_dry_blend verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // blend predictor
   // ------------------------------------------------------------------

   // coefficients and targets above one act as one
   function automatic longint capped_weight(input longint v);
      return (v > UNITY) ? UNITY : v;
   endfunction

   function automatic longint clamp_weight(input longint v);
      if (v < 0) return 0;
      if (v > UNITY) return UNITY;
      return v;
   endfunction

   // a convex blend stays in range, the clip is kept for safety
   function automatic logic signed [23:0] clip_sample(input longint v);
      if (v > 64'sd8388607) return S_MAX;
      if (v < -64'sd8388608) return S_MIN;
      return v[23:0];
   endfunction

   // one frame through the delay ring and the crossfade; advances both smoothers unless bypassed
   function automatic frame_out_type blend_frame(input frame_in_type f);
      frame_out_type r;
      longint dl, dr, dw, dry_gain, goal, coef, ol, orr;
      int     pos, rd;
      dl = f.dry_left;
      dr = f.dry_right;
      // zero latency takes the direct path and leaves the ring alone
      if (cfg_latency > 0) begin
         pos = ring_wr;
         rd  = (pos + RING_LEN - cfg_latency) % RING_LEN;
         dl  = ring_left[rd];
         dr  = ring_right[rd];
         ring_left[pos]  = f.dry_left;
         ring_right[pos] = f.dry_right;
         ring_wr = (pos + 1) % RING_LEN;
      end
      if (cfg_bypass) begin
         ol  = dl;
         orr = dr;
      end else begin
         // arithmetic shift of a signed product is the floor of the quotient
         dw       = (mix_level * fade_level) >>> 24;
         dry_gain = UNITY - dw;
         goal     = cfg_enable ? UNITY : 64'sd0;
         coef     = (goal > fade_level) ? capped_weight(cfg_rise) : capped_weight(cfg_fall);
         ol  = (dl * dry_gain + longint'(f.wet_left) * dw) >>> 24;
         orr = (dr * dry_gain + longint'(f.wet_right) * dw) >>> 24;
         mix_level = clamp_weight(mix_level +
            (((capped_weight(cfg_mix_target) - mix_level) * capped_weight(cfg_smooth)) >>> 24));
         fade_level = clamp_weight(fade_level + (((goal - fade_level) * coef) >>> 24));
      end
      r.out_left  = clip_sample(ol);
      r.out_right = clip_sample(orr);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // csr writes, only ever issued while the block is idle
   // ------------------------------------------------------------------

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_LATENCY:     cfg_latency    = value[LAT_W-1:0];
         REG_MIX_TARGET:  cfg_mix_target = value;
         REG_ENABLE:      cfg_enable     = value[0];
         REG_SMOOTH_COEF: cfg_smooth     = value;
         REG_RISE_COEF:   cfg_rise       = value;
         REG_FALL_COEF:   cfg_fall       = value;
         REG_BYPASS:      cfg_bypass     = value[0];
         default: ;
      endcase
   endtask

   // whole register set in index order; write enable drops after the last write
   task automatic configure_all(input logic [CSR_DATA_W-1:0] lat, input logic [CSR_DATA_W-1:0] mix,
                                input logic [CSR_DATA_W-1:0] en, input logic [CSR_DATA_W-1:0] smooth,
                                input logic [CSR_DATA_W-1:0] rise, input logic [CSR_DATA_W-1:0] fall,
                                input logic [CSR_DATA_W-1:0] byp);
      write_reg(REG_LATENCY, lat);
      write_reg(REG_MIX_TARGET, mix);
      write_reg(REG_ENABLE, en);
      write_reg(REG_SMOOTH_COEF, smooth);
      write_reg(REG_RISE_COEF, rise);
      write_reg(REG_FALL_COEF, fall);
      write_reg(REG_BYPASS, byp);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------

   // valid stays high across back-to-back frames; it drops only when a gap is drawn or in drain
   task automatic send_frame(input frame_in_type f);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      // transaction taken at this edge: predict with the registers now in force
      if (cfg_bypass) bypass_frames++;
      expected_frames.push_back(blend_frame(f));
      frames_sent++;
   endtask

   task automatic send_four(input logic [23:0] a, input logic [23:0] b,
                            input logic [23:0] c, input logic [23:0] d);
      frame_in_type f;
      f.dry_left  = a;
      f.dry_right = b;
      f.wet_left  = c;
      f.wet_right = d;
      send_frame(f);
   endtask

   // wait for every awaited frame, then give the sequencer time to fall idle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [23:0] random_sample();
      case ($urandom_range(0, 9))
         0: return S_MAX;
         1: return S_MIN;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic frame_in_type random_frame();
      frame_in_type f;
      f.dry_left  = random_sample();
      f.dry_right = random_sample();
      f.wet_left  = random_sample();
      f.wet_right = random_sample();
      return f;
   endfunction

   // mostly gentle coefficients so the smoothers glide, with the extremes mixed in
   function automatic logic [CSR_DATA_W-1:0] random_weight();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return W_ONE;
         2: return CSR_DATA_W'($urandom_range(int'(Q_ONE) + 1, int'(W_FULL)));
         3: return CSR_DATA_W'($urandom_range(0, int'(Q_ONE)));
         default: return CSR_DATA_W'($urandom_range(0, int'(Q_ONE) >> 4));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // output side: random back-pressure and the scoreboard check
   // ------------------------------------------------------------------

   initial begin : result_checker
      int            stall;
      frame_out_type seen, want;
      wait (reset === 1'b0);
      forever begin
         stall = back_to_back ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen = rsp_tdata;
         if (expected_frames.size() == 0) begin
            fail_count++;
            $display("unexpected result transaction: left %0d right %0d",
                     seen.out_left, seen.out_right);
         end else begin
            want = expected_frames.pop_front();
            frames_checked++;
            if (seen.out_left !== want.out_left) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("frame %0d out_left: expected %0d, got %0d",
                           frames_checked, want.out_left, seen.out_left);
            end
            if (seen.out_right !== want.out_right) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("frame %0d out_right: expected %0d, got %0d",
                           frames_checked, want.out_right, seen.out_right);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // all registers at reset: no wet weight, direct dry path
   task automatic test_reset_defaults;
      back_to_back = 1'b0;
      send_four(S_MAX, S_MIN, S_MAX, S_MIN);
      send_four(S_MIN, S_MAX, S_MIN, S_MAX);
      send_four(24'h000000, 24'hFFFFFF, S_MAX, S_MIN);
      send_frame(random_frame());
      drain();
   endtask

   // unit coefficients: first frame still dry, then fully wet
   task automatic test_full_wet;
      configure_all(0, W_ONE, 1, W_ONE, W_ONE, W_ONE, 0);
      back_to_back = 1'b1;
      send_four(S_MAX, S_MAX, S_MIN, S_MIN);
      send_four(S_MIN, S_MIN, S_MAX, S_MAX);
      send_four(S_MAX, S_MIN, 24'hFFFFFF, 24'h000000);
      send_frame(random_frame());
      drain();
   endtask

   // target and coefficients above one act as one, then fading out with fall held at one
   task automatic test_weight_saturation;
      configure_all(0, W_FULL, 1, W_FULL, W_FULL, W_FULL, 0);
      back_to_back = 1'b0;
      send_four(S_MAX, S_MIN, S_MIN, S_MAX);
      send_frame(random_frame());
      send_frame(random_frame());
      drain();
      write_reg(REG_ENABLE, 0);
      csr_we <= 1'b0;
      send_four(S_MIN, S_MAX, S_MAX, S_MIN);
      send_frame(random_frame());
      drain();
   endtask

   // deepest delay in bypass, then the shortest ring delay while mixing
   task automatic test_latency_extremes;
      configure_all(63, W_ONE, 1, W_ONE >> 1, W_ONE >> 1, W_ONE >> 2, 1);
      back_to_back = 1'b1;
      repeat (3) send_frame(random_frame());
      drain();
      configure_all(1, W_ONE >> 1, 1, W_ONE >> 1, W_ONE >> 3, W_ONE >> 3, 0);
      back_to_back = 1'b0;
      send_four(S_MAX, S_MIN, S_MIN, S_MAX);
      send_four(S_MIN, S_MAX, S_MAX, S_MIN);
      send_frame(random_frame());
      drain();
   endtask

   // random register settings, each followed by a run of random frames
   task automatic test_random_phases;
      logic [CSR_DATA_W-1:0] lat;
      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            1:       lat = 63;
            2:       lat = 0;
            default: lat = CSR_DATA_W'($urandom);  // upper bits beyond the register are dropped
         endcase
         configure_all(lat, random_weight(), CSR_DATA_W'($urandom), random_weight(),
                       random_weight(), random_weight(),
                       ($urandom_range(0, 4) == 0) ? 25'h1 : 25'h0);
         back_to_back = ($urandom_range(0, 3) == 0);
         repeat (90) begin
            // occasional stretches flip the idling mode inside a phase
            if ($urandom_range(0, 29) == 0) back_to_back = ~back_to_back;
            send_frame(random_frame());
         end
         drain();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      cycle_count = 0;
      back_to_back = 1'b0;
      cfg_latency = 0;
      cfg_mix_target = 0;
      cfg_smooth = 0;
      cfg_rise = 0;
      cfg_fall = 0;
      cfg_enable = 1'b0;
      cfg_bypass = 1'b0;
      for (int i = 0; i < RING_LEN; i++) begin
         ring_left[i]  = '0;
         ring_right[i] = '0;
      end
      ring_wr = 0;
      mix_level = 0;
      fade_level = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_full_wet();
      test_weight_saturation();
      test_latency_extremes();
      test_random_phases();

      // drain already waited out the settle time; anything still awaited is lost
      if (expected_frames.size() != 0) begin
         fail_count++;
         $display("%0d result transactions never arrived", expected_frames.size());
      end
      $display("checked %0d of %0d frames across %0d register settings (%0d in bypass)",
               frames_checked, frames_sent, settings_used, bypass_frames);
      $display("%0d field mismatches, %0d failures in %0d cycles",
               mismatch_count, fail_count, cycle_count);
      if (fail_count == 0) begin
         $display("latency_aligned_wet_dry_blend verification clean");
      end else begin
         $display("latency_aligned_wet_dry_blend verification failed");
      end
      $finish;
   end

endmodule
